// File: rtl/bbr_pkg.sv
// package: widths, constants, reciprocal table and control structs of the row box blur
`timescale 1ns / 1ps

package bbr_pkg;

   localparam int PIX_W         = 8;
   localparam int RAD_W         = 4;
   localparam int WIDTH_W       = 13;
   localparam int CFG_W         = 13;
   localparam int CSR_ADDR_W    = 1;
   localparam int SUM_W         = 13;
   localparam int COL_W         = 12;
   localparam int MAX_RADIUS    = 15;
   localparam int STORE_DEPTH   = 2 * MAX_RADIUS + 1;
   localparam int TAP_W         = $clog2(STORE_DEPTH);
   localparam int FLUSH_W       = RAD_W + 1;
   localparam int MAX_ROW_WIDTH = 4096;
   localparam int NUM_W         = SUM_W + 1;
   localparam int RECIP_SHIFT   = 19;
   localparam int RECIP_W       = RECIP_SHIFT + 1;
   localparam int PROD_W        = NUM_W + RECIP_W;

   localparam logic [RAD_W-1:0]   RADIUS_RESET    = RAD_W'(1);
   localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(640);

   localparam logic [CSR_ADDR_W-1:0] REG_RADIUS    = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_WIDTH = CSR_ADDR_W'(1);

   typedef struct packed {
      logic take_pixel;
      logic multiply;
      logic push;
      logic flush_step;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic flush_pending;
      logic out_free;
   } status_type;

   // ceil(2^19 / (2r+1)), exact quotient for numerators below 2^14
   function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
      logic [RECIP_W-1:0] v;
      v = '0;
      case (r)
         4'd0:  v = 20'd524288;
         4'd1:  v = 20'd174763;
         4'd2:  v = 20'd104858;
         4'd3:  v = 20'd74899;
         4'd4:  v = 20'd58255;
         4'd5:  v = 20'd47663;
         4'd6:  v = 20'd40330;
         4'd7:  v = 20'd34953;
         4'd8:  v = 20'd30841;
         4'd9:  v = 20'd27595;
         4'd10: v = 20'd24967;
         4'd11: v = 20'd22796;
         4'd12: v = 20'd20972;
         4'd13: v = 20'd19419;
         4'd14: v = 20'd18079;
         4'd15: v = 20'd16913;
         default: v = 20'd524288;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/bbr_ctrl.sv
// controller: sequences pixel intake, mean multiply, result push and row-end flush
`timescale 1ns / 1ps

module bbr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bbr_pkg::status_type sts,
   output bbr_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MUL   = 2'd1;
   localparam logic [1:0] S_PUSH  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take_pixel = 1'b1;
               state_in       = S_MUL;
            end
         end
         S_MUL: begin
            cmd.multiply = 1'b1;
            if (sts.emit) begin
               state_in = S_PUSH;
            end else if (sts.flush_pending) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PUSH: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = sts.flush_pending ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            cmd.flush_step = 1'b1;
            state_in       = S_MUL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/bbr_datapath.sv
// datapath: config registers, window taps, running sum, reciprocal multiply, output register
`timescale 1ns / 1ps

module bbr_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bbr_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [bbr_pkg::CFG_W-1:0]             csr_wdata,
   input  logic [bbr_pkg::PIX_W-1:0]             pixel,
   input  bbr_pkg::cmd_type                      cmd,
   output bbr_pkg::status_type                   sts,
   output logic [bbr_pkg::PIX_W-1:0]             blurred,
   output logic                                  row_end,
   output logic                                  out_valid,
   input  logic                                  out_ready
);

   logic [bbr_pkg::RAD_W-1:0]    radius_ff;
   logic [bbr_pkg::WIDTH_W-1:0]  width_ff;
   logic [bbr_pkg::COL_W-1:0]    col_ff;
   logic [bbr_pkg::COL_W-1:0]    col_hold_ff;
   logic [bbr_pkg::PIX_W-1:0]    first_ff;
   logic [bbr_pkg::SUM_W-1:0]    sum_ff;
   logic [bbr_pkg::SUM_W-1:0]    sum_in;
   logic [bbr_pkg::PIX_W-1:0]    store_ff [bbr_pkg::STORE_DEPTH];
   logic [bbr_pkg::FLUSH_W-1:0]  step_ff;
   logic                         emit_ff;
   logic                         end_ff;
   logic                         row_last_ff;
   logic [bbr_pkg::PROD_W-1:0]   product_ff;
   logic [bbr_pkg::PIX_W-1:0]    blurred_ff;
   logic                         tlast_ff;
   logic                         tvalid_ff;

   logic [bbr_pkg::TAP_W-1:0]    two_r;
   logic [bbr_pkg::TAP_W-1:0]    two_r1;
   logic [bbr_pkg::WIDTH_W-1:0]  width_eff;
   logic                         last_pix;
   logic [bbr_pkg::PIX_W-1:0]    gone_take;
   logic [bbr_pkg::PIX_W-1:0]    gone_flush;
   logic [bbr_pkg::WIDTH_W-1:0]  flush_pos;
   logic [bbr_pkg::TAP_W-1:0]    flush_tap;
   logic [bbr_pkg::SUM_W-1:0]    sum_init;
   logic [bbr_pkg::NUM_W-1:0]    numer;

   assign two_r  = {1'b0, radius_ff} << 1;
   assign two_r1 = two_r | bbr_pkg::TAP_W'(1);

   always_comb begin
      if (width_ff == '0) begin
         width_eff = bbr_pkg::WIDTH_W'(1);
      end else if (width_ff > bbr_pkg::WIDTH_W'(bbr_pkg::MAX_ROW_WIDTH)) begin
         width_eff = bbr_pkg::WIDTH_W'(bbr_pkg::MAX_ROW_WIDTH);
      end else begin
         width_eff = width_ff;
      end
   end

   assign last_pix = ({1'b0, col_ff} + bbr_pkg::WIDTH_W'(1)) >= width_eff;

   // left of row start the window holds copies of the first pixel
   assign gone_take = (bbr_pkg::WIDTH_W'(col_ff) <= bbr_pkg::WIDTH_W'(two_r1))
                      ? first_ff : store_ff[two_r];
   assign sum_init  = bbr_pkg::SUM_W'(two_r1) * bbr_pkg::SUM_W'(pixel);

   assign flush_pos  = bbr_pkg::WIDTH_W'(col_hold_ff) + bbr_pkg::WIDTH_W'(step_ff);
   assign flush_tap  = two_r1 - bbr_pkg::TAP_W'(step_ff);
   assign gone_flush = (flush_pos <= bbr_pkg::WIDTH_W'(two_r1))
                       ? first_ff : store_ff[flush_tap];

   assign numer = {1'b0, sum_ff} + bbr_pkg::NUM_W'(radius_ff);

   always_comb begin
      sum_in = sum_ff;
      if (csr_we) begin
         sum_in = '0;
      end else if (cmd.take_pixel) begin
         if (col_ff == '0) begin
            sum_in = sum_init;
         end else begin
            sum_in = sum_ff + bbr_pkg::SUM_W'(pixel) - bbr_pkg::SUM_W'(gone_take);
         end
      end else if (cmd.flush_step) begin
         sum_in = sum_ff + bbr_pkg::SUM_W'(store_ff[0]) - bbr_pkg::SUM_W'(gone_flush);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= bbr_pkg::RADIUS_RESET;
         width_ff    <= bbr_pkg::ROW_WIDTH_RESET;
         col_ff      <= '0;
         first_ff    <= '0;
         sum_ff      <= '0;
         step_ff     <= '0;
         emit_ff     <= 1'b0;
         end_ff      <= 1'b0;
         row_last_ff <= 1'b0;
         tvalid_ff   <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         if (csr_we) begin
            unique case (csr_addr)
               bbr_pkg::REG_RADIUS:    radius_ff <= csr_wdata[bbr_pkg::RAD_W-1:0];
               bbr_pkg::REG_ROW_WIDTH: width_ff  <= csr_wdata;
               default: ;
            endcase
            col_ff <= '0;
         end else if (cmd.take_pixel) begin
            if (col_ff == '0) begin
               first_ff <= pixel;
            end
            col_ff      <= last_pix ? '0 : col_ff + bbr_pkg::COL_W'(1);
            emit_ff     <= col_ff >= bbr_pkg::COL_W'(radius_ff);
            end_ff      <= last_pix && (radius_ff == '0);
            row_last_ff <= last_pix;
            step_ff     <= bbr_pkg::FLUSH_W'(1);
         end else if (cmd.flush_step) begin
            emit_ff <= flush_pos >= bbr_pkg::WIDTH_W'(radius_ff);
            end_ff  <= step_ff == {1'b0, radius_ff};
            step_ff <= step_ff + bbr_pkg::FLUSH_W'(1);
         end
         if (cmd.push) begin
            tvalid_ff <= 1'b1;
         end else if (out_ready) begin
            tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_pixel) begin
         col_hold_ff <= col_ff;
         store_ff[0] <= pixel;
         for (int i = 1; i < bbr_pkg::STORE_DEPTH; i++) begin
            store_ff[i] <= store_ff[i-1];
         end
      end
      if (cmd.multiply) begin
         product_ff <= bbr_pkg::PROD_W'(numer) * bbr_pkg::PROD_W'(bbr_pkg::recip(radius_ff));
      end
      if (cmd.push) begin
         blurred_ff <= product_ff[bbr_pkg::RECIP_SHIFT +: bbr_pkg::PIX_W];
         tlast_ff   <= end_ff;
      end
   end

   assign sts.emit          = emit_ff;
   assign sts.flush_pending = row_last_ff && (step_ff <= {1'b0, radius_ff});
   assign sts.out_free      = !tvalid_ff || out_ready;

   assign blurred   = blurred_ff;
   assign row_end   = tlast_ff;
   assign out_valid = tvalid_ff;

endmodule

// File: rtl/box_blur_row_running_sum_top.sv
// top level: horizontal box blur of a pixel row with edge replication
//
// req_* carries one 8-bit source pixel per beat, rows in raster order.
// rsp_* carries one rounded window mean per beat; rsp_tlast marks the last
// output of a row. Output j leaves after pixel j+r; the last pixel of a row
// also flushes the remaining outputs, at most r.
// csr_*: write radius (index 0) or row_width (index 1); any write restarts
// the current row. Write only while the block is idle.
// Steps: a pixel passes intake and the reciprocal multiply; one that
// yields an output also the push to the output register. At row end each
// flush step passes the multiply and, if it yields an output, the push
// (a row narrower than the window has flush steps with no output). The
// single shared multiplier and the controller's states set these steps.
// A result held in the output register does not stop the next pixel being
// taken; the controller waits in its push state only when the register is
// still occupied and rsp_tready is low.
// Reset (synchronous, active high) sets radius 1, row_width 640, empties the
// output register and starts a new row.
`timescale 1ns / 1ps

module box_blur_row_running_sum_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] pixel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] blurred
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [bbr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [bbr_pkg::CFG_W-1:0]           csr_wdata
);

   bbr_pkg::cmd_type    cmd;
   bbr_pkg::status_type sts;

   bbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bbr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .pixel     (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .blurred   (rsp_tdata),
      .row_end   (rsp_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take_pixel, cmd.multiply, cmd.push, cmd.flush_step}))
      else $error("more than one datapath command at once");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("pixel accepted while previous one still in progress");

   a_valid_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.push))
      else $error("output beat raised without a push");

   a_push_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !$past(cmd.take_pixel) && !$past(cmd.flush_step))
      else $error("push before the mean was multiplied");

endmodule

// File: verif/testbench.sv
// testbench: random and directed pixel rows through the row box blur, checked against a predictor
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [7:0] blurred;
      logic       row_end;
   } mean_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;   // [7:0] pixel
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;        // [7:0] blurred
   logic                           rsp_tlast;
   logic                           csr_we = 1'b0;
   logic [bbr_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [bbr_pkg::CFG_W-1:0]      csr_wdata = '0;

   logic [7:0]  pix_queue[$];
   mean_type    mean_queue[$];
   mean_type    want;
   int          pixels_queued = 0;
   int          mismatches = 0;
   int          send_idle_pct = 37;
   int          recv_idle_pct = 64;
   logic        req_fire = 1'b0;

   // predictor state
   logic [bbr_pkg::RAD_W-1:0]   cur_radius;
   logic [bbr_pkg::WIDTH_W-1:0] cur_width;
   logic [7:0]                  recent_pix[bbr_pkg::STORE_DEPTH];
   logic [bbr_pkg::SUM_W-1:0]   win_sum;
   logic [bbr_pkg::COL_W-1:0]   col_idx;
   logic [7:0]                  row_first;

   box_blur_row_running_sum_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] leaving_pixel(input int pos, input int age);
      return (pos <= 0) ? row_first : recent_pix[age];
   endfunction

   function automatic void push_mean(input int r, input bit is_end);
      mean_type e;
      e.blurred = 8'((int'(win_sum) + r) / (2 * r + 1));
      e.row_end = is_end;
      mean_queue.push_back(e);
   endfunction

   function automatic void apply_csr(input logic [bbr_pkg::CSR_ADDR_W-1:0] idx,
                                     input logic [bbr_pkg::CFG_W-1:0] val);
      if (idx == bbr_pkg::REG_RADIUS) begin
         cur_radius = val[bbr_pkg::RAD_W-1:0];
      end else if (idx == bbr_pkg::REG_ROW_WIDTH) begin
         cur_width = val[bbr_pkg::WIDTH_W-1:0];
      end
      win_sum = '0;
      col_idx = '0;
   endfunction

   function automatic void slide_window(input logic [7:0] p);
      int r;
      int w;
      int c;
      int m;
      int v;
      int i;
      bit last;
      r = int'(cur_radius);
      w = int'(cur_width);
      if (w == 0) w = 1;
      if (w > bbr_pkg::MAX_ROW_WIDTH) w = bbr_pkg::MAX_ROW_WIDTH;
      c = int'(col_idx);
      last = (c + 1 >= w);
      if (c == 0) begin
         row_first = p;
         win_sum = bbr_pkg::SUM_W'((2 * r + 1) * int'(p));
      end else begin
         win_sum = bbr_pkg::SUM_W'(int'(win_sum) + int'(p)
                                   - int'(leaving_pixel(c - 2 * r - 1, 2 * r)));
      end
      for (i = bbr_pkg::STORE_DEPTH - 1; i > 0; i--) recent_pix[i] = recent_pix[i-1];
      recent_pix[0] = p;
      if (c - r >= 0) push_mean(r, last && r == 0);
      if (last) begin
         for (m = 1; m <= r; m++) begin
            v = c - r + m;
            win_sum = bbr_pkg::SUM_W'(int'(win_sum) + int'(p)
                                      - int'(leaving_pixel(v - 1 - r, 2 * r + 1 - m)));
            if (v >= 0) push_mean(r, m == r);
         end
         col_idx = '0;
      end else begin
         col_idx = bbr_pkg::COL_W'(c + 1);
      end
   endfunction

   // predictor update and result check
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      if (reset) begin
         cur_radius = bbr_pkg::RADIUS_RESET;
         cur_width  = bbr_pkg::ROW_WIDTH_RESET;
         win_sum    = '0;
         col_idx    = '0;
         row_first  = '0;
      end else begin
         if (csr_we) apply_csr(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) slide_window(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (mean_queue.size() == 0) begin
               $display("%0t: unexpected beat, actual blurred=%0d last=%0b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = mean_queue.pop_front();
               if (rsp_tdata !== want.blurred || rsp_tlast !== want.row_end) begin
                  $display("%0t: expected blurred=%0d last=%0b, actual blurred=%0d last=%0b",
                           $time, want.blurred, want.row_end, rsp_tdata, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   // pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pix_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pix_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_pixel(input logic [7:0] p);
      pix_queue.push_back(p);
      pixels_queued++;
   endtask

   function automatic logic [7:0] rand_pixel();
      int sel;
      sel = $urandom_range(7);
      if (sel == 0) return 8'd0;
      if (sel == 1) return 8'd255;
      return 8'($urandom);
   endfunction

   task automatic settle();
      while (pix_queue.size() != 0 || req_tvalid || mean_queue.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bbr_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [bbr_pkg::CFG_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_segment();
      int r;
      int w;
      int weff;
      int rows;
      int k;
      int i;
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) r = 0;
      else if (sel == 1) r = bbr_pkg::MAX_RADIUS;
      else r = $urandom_range(0, bbr_pkg::MAX_RADIUS);
      sel = $urandom_range(9);
      if (sel == 0) w = $urandom_range(0, 2 * r);
      else if (sel == 1) w = 2 * r + 1;
      else w = 2 * r + 1 + $urandom_range(0, 10);
      weff = (w == 0) ? 1 : w;
      settle();
      if ($urandom_range(1) == 0) begin
         write_csr(bbr_pkg::REG_RADIUS, {9'($urandom), 4'(r)});
         write_csr(bbr_pkg::REG_ROW_WIDTH, bbr_pkg::CFG_W'(w));
      end else begin
         write_csr(bbr_pkg::REG_ROW_WIDTH, bbr_pkg::CFG_W'(w));
         write_csr(bbr_pkg::REG_RADIUS, {9'($urandom), 4'(r)});
      end
      rows = $urandom_range(1, 3);
      for (k = 0; k < rows; k++)
         for (i = 0; i < weff; i++) queue_pixel(rand_pixel());
      // unfinished row, cut short by the next register write
      if (weff > 1 && $urandom_range(3) == 0)
         for (i = $urandom_range(1, weff - 1); i > 0; i--) queue_pixel(rand_pixel());
   endtask

   task automatic random_phase(input int s_idle, input int r_idle, input int count);
      int target;
      settle();
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      target = pixels_queued + count;
      while (pixels_queued < target) random_segment();
   endtask

   initial begin
      int i;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, then a write in mid-row restarts it
      queue_pixel(8'd10);
      queue_pixel(8'd200);
      queue_pixel(8'd30);
      settle();
      // radius zero passes pixels straight through
      write_csr(bbr_pkg::REG_RADIUS, bbr_pkg::CFG_W'(0));
      write_csr(bbr_pkg::REG_ROW_WIDTH, bbr_pkg::CFG_W'(5));
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      queue_pixel(8'd128);
      settle();
      // row far narrower than the window
      write_csr(bbr_pkg::REG_RADIUS, bbr_pkg::CFG_W'(15));
      write_csr(bbr_pkg::REG_ROW_WIDTH, bbr_pkg::CFG_W'(3));
      queue_pixel(8'd255);
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      settle();
      // zero width behaves as one pixel per row
      write_csr(bbr_pkg::REG_RADIUS, bbr_pkg::CFG_W'(2));
      write_csr(bbr_pkg::REG_ROW_WIDTH, bbr_pkg::CFG_W'(0));
      queue_pixel(8'd255);
      queue_pixel(8'd0);
      settle();
      write_csr(bbr_pkg::REG_RADIUS, bbr_pkg::CFG_W'(1));
      write_csr(bbr_pkg::REG_ROW_WIDTH, bbr_pkg::CFG_W'(3));
      queue_pixel(8'd255);
      queue_pixel(8'd255);
      queue_pixel(8'd1);

      random_phase(37, 64, 90);
      random_phase(64, 37, 90);
      random_phase(0, 0, 90);

      // radius and width saturated from all-ones writes, start of a wide row
      settle();
      write_csr(bbr_pkg::REG_RADIUS, bbr_pkg::CFG_W'(13'h1FFF));
      write_csr(bbr_pkg::REG_ROW_WIDTH, bbr_pkg::CFG_W'(13'h1FFF));
      for (i = 0; i < 20; i++) queue_pixel(rand_pixel());

      settle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && mean_queue.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
